// ===== rtl/nrmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the NMEA RMC sentence decoder.
// No dependencies; used by the parser, the core and the checker.
package nrmc_pkg;

	// Defaults for the top-level parameters
	localparam int FRAC_DIGITS_DEF = 5;
	localparam int MAX_FIELDS_DEF  = 31;

	// Result port widths
	localparam int YEAR_W   = 12;
	localparam int DIG_W    = 7;
	localparam int MILLIS_W = 10;
	localparam int LAT_W    = 31;
	localparam int LON_W    = 35;

	// Minutes fraction accumulator, held in units of 1e-7 minute
	localparam int FRAC_W = 24;

	// Angle conversion: minutes in 1e-7 minute plus rounding, quotient by 60
	localparam int X_W         = 30;
	localparam int Q_W         = 24;
	localparam int DLAT_W      = 30;
	localparam int DLON_W      = 34;
	localparam int DEG_SCALE   = 10_000_000;
	localparam int ROUND_HALF  = 30;
	localparam int MIN_PER_DEG = 60;
	localparam int RECIP_SHIFT = 36;
	localparam int RECIP_W     = 31;
	localparam int PROD_W      = X_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_60 =
		RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(MIN_PER_DEG));

	// Date and time scaling
	localparam int YEAR_BASE    = 2000;
	localparam int MS_PER_TENTH = 100;

	// Sentence contents collected by the parser
	typedef struct packed {
		logic              id_match;
		logic              status_match;
		logic [DIG_W-1:0]  hours;
		logic [DIG_W-1:0]  mins;
		logic [DIG_W-1:0]  secs;
		logic [3:0]        tenth;
		logic [DIG_W-1:0]  day;
		logic [DIG_W-1:0]  month;
		logic [DIG_W-1:0]  yr;
		logic [6:0]        lat_deg;
		logic [6:0]        lat_int;
		logic [FRAC_W-1:0] lat_frac;
		logic              south;
		logic [9:0]        lon_deg;
		logic [6:0]        lon_int;
		logic [FRAC_W-1:0] lon_frac;
		logic              west;
	} sentence_t;

endpackage

// ===== rtl/nrmc_parser.sv =====
`timescale 1ns / 1ps
// Character parser of the NMEA RMC sentence decoder: splits fields at commas
// and collects id, status, time, date and angle digits. Depends on nrmc_pkg.
module nrmc_parser #(
	parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF,
	parameter int MAX_FIELDS  = nrmc_pkg::MAX_FIELDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          ch,
	input  logic                last,
	output logic                done,
	output logic                fix,
	output nrmc_pkg::sentence_t snap
);
	import nrmc_pkg::*;

	localparam int FW  = $clog2(MAX_FIELDS + 1);
	localparam int FCW = $clog2(FRAC_DIGITS + 1);

	localparam logic [7:0] ASC_COMMA = 8'h2C;
	localparam logic [7:0] ASC_POINT = 8'h2E;
	localparam logic [7:0] ASC_ZERO  = 8'h30;
	localparam logic [7:0] ASC_NINE  = 8'h39;
	localparam logic [7:0] ASC_A     = 8'h41;
	localparam logic [7:0] ASC_S     = 8'h53;
	localparam logic [7:0] ASC_W     = 8'h57;

	localparam logic [FW-1:0] FLD_ID     = FW'(0);
	localparam logic [FW-1:0] FLD_TIME   = FW'(1);
	localparam logic [FW-1:0] FLD_STATUS = FW'(2);
	localparam logic [FW-1:0] FLD_LAT    = FW'(3);
	localparam logic [FW-1:0] FLD_NS     = FW'(4);
	localparam logic [FW-1:0] FLD_LON    = FW'(5);
	localparam logic [FW-1:0] FLD_EW     = FW'(6);
	localparam logic [FW-1:0] FLD_DATE   = FW'(9);

	localparam logic [4:0] ID_LEN      = 5'd6;
	localparam logic [4:0] PAIR_LEN    = 5'd6;
	localparam logic [4:0] TENTH_POS   = 5'd7;
	localparam logic [4:0] LAT_DEG_LEN = 5'd2;
	localparam logic [4:0] LON_DEG_LEN = 5'd3;
	localparam logic [4:0] POS_MAX     = 5'd31;

	// Working state of the field being read
	typedef struct packed {
		logic [2:0]        part_bad;
		logic              sub_bad;
		logic [6:0]        min_int;
		logic [1:0]        min_cnt;
		logic              min_point;
		logic [FRAC_W-1:0] frac;
		logic [FCW-1:0]    fcnt;
	} work_t;

	localparam sentence_t SENT_CLEAR = '{id_match: 1'b1, default: '0};

	logic [FW-1:0] field_q, field_d;
	logic [4:0]    pos_q, pos_d;
	work_t         work_q, work_d;
	sentence_t     sent_q, sent_d;

	// Expected id characters "$GPRMC"
	function automatic logic [7:0] id_char(logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Weight of a minutes fraction digit in 1e-7 minute
	function automatic logic [FRAC_W-1:0] frac_weight(logic [2:0] c);
		logic [FRAC_W-1:0] w;
		unique case (c)
			3'd0: w = FRAC_W'(1_000_000);
			3'd1: w = FRAC_W'(100_000);
			3'd2: w = FRAC_W'(10_000);
			3'd3: w = FRAC_W'(1_000);
			3'd4: w = FRAC_W'(100);
			3'd5: w = FRAC_W'(10);
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [6:0] push7(logic [6:0] v, logic [3:0] d);
		return 7'(v * 7'd10 + 7'(d));
	endfunction

	function automatic logic [9:0] push10(logic [9:0] v, logic [3:0] d);
		return 10'(v * 10'd10 + 10'(d));
	endfunction

	// Take one character of the minutes subfield
	function automatic work_t minutes_char(work_t w, logic [7:0] c);
		work_t r;
		logic  dig;
		r   = w;
		dig = (c >= ASC_ZERO) && (c <= ASC_NINE);
		if (dig) begin
			if (!w.min_point) begin
				if (w.min_cnt >= 2'd2) begin
					r.sub_bad = 1'b1;
				end else begin
					r.min_int = push7(w.min_int, c[3:0]);
					r.min_cnt = w.min_cnt + 2'd1;
				end
			end else if (w.fcnt < FCW'(FRAC_DIGITS)) begin
				r.frac = w.frac + FRAC_W'(frac_weight(3'(w.fcnt)) * FRAC_W'(c[3:0]));
				r.fcnt = w.fcnt + FCW'(1);
			end
		end else if (c == ASC_POINT && !w.min_point) begin
			r.min_point = 1'b1;
		end else begin
			r.sub_bad = 1'b1;
		end
		return r;
	endfunction

	// Finish a field: check id length, drop bad subfields, latch minutes
	function automatic sentence_t close_field(sentence_t s, logic [FW-1:0] fld,
			logic [4:0] pos, work_t w);
		sentence_t r;
		r = s;
		unique case (fld)
			FLD_ID: begin
				if (pos != ID_LEN) r.id_match = 1'b0;
			end
			FLD_TIME: begin
				if (w.part_bad[0]) r.hours = '0;
				if (w.part_bad[1]) r.mins = '0;
				if (w.part_bad[2]) r.secs = '0;
			end
			FLD_LAT: begin
				if (w.part_bad[0]) r.lat_deg = '0;
				r.lat_int  = w.sub_bad ? '0 : w.min_int;
				r.lat_frac = w.sub_bad ? '0 : w.frac;
			end
			FLD_LON: begin
				if (w.part_bad[0]) r.lon_deg = '0;
				r.lon_int  = w.sub_bad ? '0 : w.min_int;
				r.lon_frac = w.sub_bad ? '0 : w.frac;
			end
			FLD_DATE: begin
				if (w.part_bad[0]) r.day = '0;
				if (w.part_bad[1]) r.month = '0;
				if (w.part_bad[2]) r.yr = '0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Apply one character, then close the sentence on the last one
	always_comb begin
		sentence_t     sa;
		sentence_t     sb;
		work_t         wa;
		logic [FW-1:0] fa;
		logic [4:0]    pa;
		logic          dig;
		logic [3:0]    d;
		logic [1:0]    k;

		sa  = sent_q;
		wa  = work_q;
		fa  = field_q;
		pa  = pos_q;
		dig = (ch >= ASC_ZERO) && (ch <= ASC_NINE);
		d   = dig ? ch[3:0] : 4'd0;
		k   = pos_q[2:1];

		if (ch == ASC_COMMA) begin
			sa = close_field(sent_q, field_q, pos_q, work_q);
			wa = '0;
			pa = '0;
			if (field_q < FW'(MAX_FIELDS)) fa = field_q + FW'(1);
		end else begin
			unique case (field_q)
				FLD_ID: begin
					if (pos_q >= ID_LEN || ch != id_char(pos_q[2:0])) sa.id_match = 1'b0;
				end
				FLD_TIME: begin
					if (pos_q < PAIR_LEN) begin
						if (dig) begin
							unique case (k)
								2'd0: sa.hours = push7(sent_q.hours, d);
								2'd1: sa.mins = push7(sent_q.mins, d);
								default: sa.secs = push7(sent_q.secs, d);
							endcase
						end else begin
							wa.part_bad = work_q.part_bad | (3'b001 << k);
						end
					end else if (pos_q == TENTH_POS) begin
						sa.tenth = d;
					end
				end
				FLD_STATUS: sa.status_match = (pos_q == 5'd0) && (ch == ASC_A);
				FLD_LAT: begin
					if (pos_q < LAT_DEG_LEN) begin
						if (dig) sa.lat_deg = push7(sent_q.lat_deg, d);
						else wa.part_bad[0] = 1'b1;
					end else begin
						wa = minutes_char(work_q, ch);
					end
				end
				FLD_NS: sa.south = (pos_q == 5'd0) && (ch == ASC_S);
				FLD_LON: begin
					if (pos_q < LON_DEG_LEN) begin
						if (dig) sa.lon_deg = push10(sent_q.lon_deg, d);
						else wa.part_bad[0] = 1'b1;
					end else begin
						wa = minutes_char(work_q, ch);
					end
				end
				FLD_EW: sa.west = (pos_q == 5'd0) && (ch == ASC_W);
				FLD_DATE: begin
					if (pos_q < PAIR_LEN) begin
						if (dig) begin
							unique case (k)
								2'd0: sa.day = push7(sent_q.day, d);
								2'd1: sa.month = push7(sent_q.month, d);
								default: sa.yr = push7(sent_q.yr, d);
							endcase
						end else begin
							wa.part_bad = work_q.part_bad | (3'b001 << k);
						end
					end
				end
				default: begin
				end
			endcase
			if (pos_q != POS_MAX) pa = pos_q + 5'd1;
		end

		sb   = close_field(sa, fa, pa, wa);
		snap = sb;
		fix  = sb.id_match && sb.status_match && (fa >= FLD_DATE);
		done = accept && last;

		if (last) begin
			sent_d  = SENT_CLEAR;
			work_d  = '0;
			field_d = '0;
			pos_d   = '0;
		end else begin
			sent_d  = sa;
			work_d  = wa;
			field_d = fa;
			pos_d   = pa;
		end
	end

	// Advance parser state on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q  <= SENT_CLEAR;
			work_q  <= '0;
			field_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			sent_q  <= sent_d;
			work_q  <= work_d;
			field_q <= field_d;
			pos_q   <= pos_d;
		end
	end

endmodule

// ===== rtl/nmea_rmc_sentence_decoder_core.sv =====
`timescale 1ns / 1ps
// Top level of the NMEA RMC sentence decoder: parser plus angle conversion
// pipeline and output register. Depends on nrmc_pkg and nrmc_parser.

// Takes one sentence character per clock while char_stall is low and gives one
// result per sentence: after the transfer of the character marked last, the
// sentence passes the result stages to raise result_valid. Characters stream at
// one per cycle with no gaps while char_stall is low; the five result stages
// (snapshot, scaling, reciprocal multiply for the division of minutes by 60,
// quotient correction, sign and output register) each hold one sentence, and
// char_stall rises only when all of them are full and the output is stalled.
// When fix_valid is low every other result field is zero.
module nmea_rmc_sentence_decoder_core #(
	parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF,
	parameter int MAX_FIELDS  = nrmc_pkg::MAX_FIELDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [7:0]                          ch,
	input  logic                                last,
	input  logic                                char_valid,
	output logic                                char_stall,
	output logic                                fix_valid,
	output logic [nrmc_pkg::YEAR_W-1:0]         year,
	output logic [nrmc_pkg::DIG_W-1:0]          month,
	output logic [nrmc_pkg::DIG_W-1:0]          day,
	output logic [nrmc_pkg::DIG_W-1:0]          hours,
	output logic [nrmc_pkg::DIG_W-1:0]          mins,
	output logic [nrmc_pkg::DIG_W-1:0]          secs,
	output logic [nrmc_pkg::MILLIS_W-1:0]       millis,
	output logic signed [nrmc_pkg::LAT_W-1:0]   latitude,
	output logic signed [nrmc_pkg::LON_W-1:0]   longitude,
	output logic                                result_valid,
	input  logic                                result_stall
);
	import nrmc_pkg::*;

	typedef struct packed {
		logic                fix;
		logic [YEAR_W-1:0]   year;
		logic [DIG_W-1:0]    month;
		logic [DIG_W-1:0]    day;
		logic [DIG_W-1:0]    hours;
		logic [DIG_W-1:0]    mins;
		logic [DIG_W-1:0]    secs;
		logic [MILLIS_W-1:0] millis;
	} stamp_t;

	logic      accept;
	logic      p_done;
	logic      p_fix;
	sentence_t p_snap;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	sentence_t snap_s1;
	logic      fix_s1;

	stamp_t             stamp_d, stamp_s2, stamp_s3, stamp_s4, stamp_s5;
	logic [X_W-1:0]     lat_x_s2, lon_x_s2, lat_x_s3, lon_x_s3;
	logic [DLAT_W-1:0]  lat_dg_s2, lat_dg_s3, lat_dg_s4;
	logic [DLON_W-1:0]  lon_dg_s2, lon_dg_s3, lon_dg_s4;
	logic               south_s2, south_s3, south_s4;
	logic               west_s2, west_s3, west_s4;
	logic [PROD_W-1:0]  lat_prod, lon_prod;
	logic [Q_W-1:0]     lat_q0_s3, lon_q0_s3, lat_q_s4, lon_q_s4;
	logic [X_W-1:0]     lat_r, lon_r;
	logic [LAT_W-1:0]   lat_mag;
	logic [LON_W-1:0]   lon_mag;
	logic signed [LAT_W-1:0] lat_s5;
	logic signed [LON_W-1:0] lon_s5;

	assign accept = char_valid && !char_stall;

	nrmc_parser #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.MAX_FIELDS (MAX_FIELDS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.ch    (ch),
		.last  (last),
		.done  (p_done),
		.fix   (p_fix),
		.snap  (p_snap)
	);

	// Collapse bubbles: a stage takes new data when empty or when it drains
	assign rdy5       = !v_s5 || !result_stall;
	assign rdy4       = !v_s4 || rdy5;
	assign rdy3       = !v_s3 || rdy4;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign char_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= p_done;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: hold the closed sentence, zeroed when it is no valid fix
	always_ff @(posedge clk) begin
		if (rdy1 && p_done) begin
			snap_s1 <= p_fix ? p_snap : '0;
			fix_s1  <= p_fix;
		end
	end

	// Stage 2: scale date, time and minutes; degrees to 1e-7 degree
	always_comb begin
		stamp_d.fix    = fix_s1;
		stamp_d.year   = fix_s1 ? YEAR_W'(YEAR_BASE) + YEAR_W'(snap_s1.yr) : '0;
		stamp_d.month  = snap_s1.month;
		stamp_d.day    = snap_s1.day;
		stamp_d.hours  = snap_s1.hours;
		stamp_d.mins   = snap_s1.mins;
		stamp_d.secs   = snap_s1.secs;
		stamp_d.millis = MILLIS_W'(MILLIS_W'(snap_s1.tenth) * MILLIS_W'(MS_PER_TENTH));
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			stamp_s2  <= stamp_d;
			lat_x_s2  <= X_W'(X_W'(snap_s1.lat_int) * X_W'(DEG_SCALE))
			           + X_W'(snap_s1.lat_frac) + X_W'(ROUND_HALF);
			lon_x_s2  <= X_W'(X_W'(snap_s1.lon_int) * X_W'(DEG_SCALE))
			           + X_W'(snap_s1.lon_frac) + X_W'(ROUND_HALF);
			lat_dg_s2 <= DLAT_W'(DLAT_W'(snap_s1.lat_deg) * DLAT_W'(DEG_SCALE));
			lon_dg_s2 <= DLON_W'(DLON_W'(snap_s1.lon_deg) * DLON_W'(DEG_SCALE));
			south_s2  <= snap_s1.south;
			west_s2   <= snap_s1.west;
		end
	end

	// Stage 3: estimate minutes / 60 by reciprocal multiply
	assign lat_prod = PROD_W'(lat_x_s2) * PROD_W'(RECIP_60);
	assign lon_prod = PROD_W'(lon_x_s2) * PROD_W'(RECIP_60);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			stamp_s3  <= stamp_s2;
			lat_x_s3  <= lat_x_s2;
			lon_x_s3  <= lon_x_s2;
			lat_q0_s3 <= lat_prod[RECIP_SHIFT +: Q_W];
			lon_q0_s3 <= lon_prod[RECIP_SHIFT +: Q_W];
			lat_dg_s3 <= lat_dg_s2;
			lon_dg_s3 <= lon_dg_s2;
			south_s3  <= south_s2;
			west_s3   <= west_s2;
		end
	end

	// Stage 4: the estimate is at most one low; fix it from the remainder
	assign lat_r = lat_x_s3 - X_W'(X_W'(lat_q0_s3) * X_W'(MIN_PER_DEG));
	assign lon_r = lon_x_s3 - X_W'(X_W'(lon_q0_s3) * X_W'(MIN_PER_DEG));

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			stamp_s4  <= stamp_s3;
			lat_q_s4  <= lat_q0_s3 + Q_W'(lat_r >= X_W'(MIN_PER_DEG));
			lon_q_s4  <= lon_q0_s3 + Q_W'(lon_r >= X_W'(MIN_PER_DEG));
			lat_dg_s4 <= lat_dg_s3;
			lon_dg_s4 <= lon_dg_s3;
			south_s4  <= south_s3;
			west_s4   <= west_s3;
		end
	end

	// Stage 5: add degrees, apply hemisphere sign, hold for the transfer
	assign lat_mag = LAT_W'(lat_dg_s4) + LAT_W'(lat_q_s4);
	assign lon_mag = LON_W'(lon_dg_s4) + LON_W'(lon_q_s4);

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			stamp_s5 <= stamp_s4;
			lat_s5   <= south_s4 ? -lat_mag : lat_mag;
			lon_s5   <= west_s4 ? -lon_mag : lon_mag;
		end
	end

	assign result_valid = v_s5;
	assign fix_valid    = stamp_s5.fix;
	assign year         = stamp_s5.year;
	assign month        = stamp_s5.month;
	assign day          = stamp_s5.day;
	assign hours        = stamp_s5.hours;
	assign mins         = stamp_s5.mins;
	assign secs         = stamp_s5.secs;
	assign millis       = stamp_s5.millis;
	assign latitude     = lat_s5;
	assign longitude    = lon_s5;

endmodule

// ===== rtl/nrmc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the NMEA RMC sentence decoder, bound to its top level.
// Depends on nrmc_pkg and nmea_rmc_sentence_decoder_core.
module nrmc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                char_stall,
	input logic                                fix_valid,
	input logic [nrmc_pkg::YEAR_W-1:0]         year,
	input logic [nrmc_pkg::DIG_W-1:0]          month,
	input logic [nrmc_pkg::DIG_W-1:0]          day,
	input logic [nrmc_pkg::DIG_W-1:0]          hours,
	input logic [nrmc_pkg::DIG_W-1:0]          mins,
	input logic [nrmc_pkg::DIG_W-1:0]          secs,
	input logic [nrmc_pkg::MILLIS_W-1:0]       millis,
	input logic signed [nrmc_pkg::LAT_W-1:0]   latitude,
	input logic signed [nrmc_pkg::LON_W-1:0]   longitude,
	input logic                                result_valid,
	input logic                                result_stall
);
	import nrmc_pkg::*;

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(fix_valid)
			&& $stable(latitude) && $stable(longitude) && $stable(year))
		else $error("stalled result changed");

	// Stall characters only when the output stage holds a result and is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> result_valid && result_stall)
		else $error("character stall without a blocked result");

	// Zero every field of a result that is no valid fix
	a_no_fix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !fix_valid |-> year == '0 && month == '0 && day == '0
			&& hours == '0 && mins == '0 && secs == '0 && millis == '0
			&& latitude == '0 && longitude == '0)
		else $error("invalid fix with nonzero fields");

	// Keep year and milliseconds of a valid fix in range
	a_fix_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fix_valid |-> year >= YEAR_W'(YEAR_BASE)
			&& year <= YEAR_W'(YEAR_BASE + 99) && millis <= MILLIS_W'(900))
		else $error("year or milliseconds out of range");

endmodule

bind nmea_rmc_sentence_decoder_core nrmc_checker u_nrmc_checker (.*);
